// ===== hw/rtl/cbot_pkg.sv =====
package cbot_pkg;

  // control that travels with an item through the distance stage
  typedef struct packed {
    logic valid;
    logic point;
    logic a_box;
    logic b_box;
  } cbot_ctl_t;

  // control that travels with an item after the test has been reduced
  typedef struct packed {
    logic valid;
    logic round;
    logic box_hit;
  } cbot_tst_t;

  // number of register stages from start to out_valid
  localparam int unsigned LATENCY = 4;

endpackage

// ===== hw/rtl/cbot_dist.sv =====
module cbot_dist #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cbot_pkg::cbot_ctl_t      ctl_in,
  input  logic [COORD_WIDTH-1:0]   a_x,
  input  logic [COORD_WIDTH-1:0]   a_y,
  input  logic [COORD_WIDTH-2:0]   a_size_x,
  input  logic [COORD_WIDTH-2:0]   a_size_y,
  input  logic [COORD_WIDTH-1:0]   b_x,
  input  logic [COORD_WIDTH-1:0]   b_y,
  input  logic [COORD_WIDTH-2:0]   b_size_x,
  input  logic [COORD_WIDTH-2:0]   b_size_y,
  output cbot_pkg::cbot_ctl_t      ctl_r,
  output logic [COORD_WIDTH-1:0]   dx_r,
  output logic [COORD_WIDTH-1:0]   dy_r,
  output logic [COORD_WIDTH-2:0]   asx_r,
  output logic [COORD_WIDTH-2:0]   asy_r,
  output logic [COORD_WIDTH-2:0]   bsx_r,
  output logic [COORD_WIDTH-2:0]   bsy_r
);
  import cbot_pkg::*;

  localparam int unsigned W = COORD_WIDTH;

  logic [W:0]   x_ab, x_ba, y_ab, y_ba;
  logic [W-1:0] dx_nxt, dy_nxt;
  cbot_ctl_t    ctl_nxt;

  // absolute centre distance per axis, both orders in parallel
  always_comb begin
    x_ab   = {a_x[W-1], a_x} - {b_x[W-1], b_x};
    x_ba   = {b_x[W-1], b_x} - {a_x[W-1], a_x};
    y_ab   = {a_y[W-1], a_y} - {b_y[W-1], b_y};
    y_ba   = {b_y[W-1], b_y} - {a_y[W-1], a_y};
    dx_nxt = x_ab[W] ? x_ba[W-1:0] : x_ab[W-1:0];
    dy_nxt = y_ab[W] ? y_ba[W-1:0] : y_ab[W-1:0];
    ctl_nxt = ctl_in;
  end

  // control register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    dx_r  <= dx_nxt;
    dy_r  <= dy_nxt;
    asx_r <= a_size_x;
    asy_r <= a_size_y;
    bsx_r <= b_size_x;
    bsy_r <= b_size_y;
  end

endmodule

// ===== hw/rtl/cbot_reduce.sv =====
module cbot_reduce #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cbot_pkg::cbot_ctl_t      ctl,
  input  logic [COORD_WIDTH-1:0]   dx,
  input  logic [COORD_WIDTH-1:0]   dy,
  input  logic [COORD_WIDTH-2:0]   asx,
  input  logic [COORD_WIDTH-2:0]   asy,
  input  logic [COORD_WIDTH-2:0]   bsx,
  input  logic [COORD_WIDTH-2:0]   bsy,
  output cbot_pkg::cbot_tst_t      tst_r,
  output logic [COORD_WIDTH-1:0]   gx_r,
  output logic [COORD_WIDTH-1:0]   gy_r,
  output logic [COORD_WIDTH-1:0]   rad_r
);
  import cbot_pkg::*;

  localparam int unsigned W = COORD_WIDTH;

  logic [W-1:0] ax_w, ay_w, bx_w, by_w;
  logic [W-1:0] sum_x, sum_y;
  logic [W-1:0] hx, hy;
  logic [W-1:0] gx_nxt, gy_nxt, rad_nxt;
  cbot_tst_t    tst_nxt;

  // extend sizes and form the half size sums
  always_comb begin
    ax_w  = {1'b0, asx};
    ay_w  = {1'b0, asy};
    bx_w  = {1'b0, bsx};
    by_w  = {1'b0, bsy};
    sum_x = ax_w + bx_w;
    sum_y = ay_w + by_w;
    // box whose gap the circle centre is measured to
    hx    = ctl.a_box ? ax_w : bx_w;
    hy    = ctl.a_box ? ay_w : by_w;
  end

  // reduce every test to a box verdict or a gap against a radius
  always_comb begin
    tst_nxt.valid   = ctl.valid;
    tst_nxt.round   = 1'b1;
    tst_nxt.box_hit = 1'b0;
    gx_nxt          = dx;
    gy_nxt          = dy;
    rad_nxt         = ax_w;
    if (ctl.point) begin
      if (ctl.a_box) begin
        tst_nxt.round   = 1'b0;
        tst_nxt.box_hit = (dx <= ax_w) && (dy <= ay_w);
      end
    end else if (ctl.a_box && ctl.b_box) begin
      tst_nxt.round   = 1'b0;
      tst_nxt.box_hit = (dx <= sum_x) && (dy <= sum_y);
    end else if (ctl.a_box || ctl.b_box) begin
      gx_nxt  = (dx > hx) ? dx - hx : '0;
      gy_nxt  = (dy > hy) ? dy - hy : '0;
      rad_nxt = ctl.a_box ? bx_w : ax_w;
    end else begin
      rad_nxt = sum_x;
    end
  end

  // control register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tst_r <= '0;
    end else begin
      tst_r <= tst_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    gx_r  <= gx_nxt;
    gy_r  <= gy_nxt;
    rad_r <= rad_nxt;
  end

endmodule

// ===== hw/rtl/cbot_radius.sv =====
module cbot_radius #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cbot_pkg::cbot_tst_t      tst,
  input  logic [COORD_WIDTH-1:0]   gx,
  input  logic [COORD_WIDTH-1:0]   gy,
  input  logic [COORD_WIDTH-1:0]   rad,
  output logic                     valid_r,
  output logic                     hit_r
);
  import cbot_pkg::*;

  localparam int unsigned W = COORD_WIDTH;

  cbot_tst_t      sq_tst_r;
  logic           far_r;
  logic [2*W-1:0] sx_r, sy_r, r2_r;
  logic           far_nxt;
  logic [2*W:0]   dist2;
  logic           hit_nxt;

  // squaring stage, gaps beyond the radius settle the test early
  always_comb begin
    far_nxt = (gx > rad) || (gy > rad);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_tst_r <= '0;
    end else begin
      sq_tst_r <= tst;
    end
  end

  always_ff @(posedge clk) begin
    far_r <= far_nxt;
    sx_r  <= {{W{1'b0}}, gx} * {{W{1'b0}}, gx};
    sy_r  <= {{W{1'b0}}, gy} * {{W{1'b0}}, gy};
    r2_r  <= {{W{1'b0}}, rad} * {{W{1'b0}}, rad};
  end

  // compare stage, squared distance against squared radius
  always_comb begin
    dist2   = {1'b0, sx_r} + {1'b0, sy_r};
    hit_nxt = sq_tst_r.round ? (!far_r && (dist2 <= {1'b0, r2_r})) : sq_tst_r.box_hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= sq_tst_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    hit_r <= hit_nxt;
  end

endmodule

// ===== hw/rtl/circle_box_overlap_test_unit.sv =====
// 2D narrow-phase overlap test for circles, axis-aligned boxes and points.
// An item is taken on every clock edge where start is high; busy never rises,
// so one item per cycle goes in without a gap. The verdict appears on out_hit
// with out_valid high for exactly one cycle, in the order the items came in;
// the receiver cannot hold it off and must take it then. The verdict passes
// four register stages: centre distance, reduction of the test to a gap and
// a radius, the three squarers, and the final compare.
// Boundaries count as a hit. No state is kept between items.
module circle_box_overlap_test_unit #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic                   in_kind,
  input  logic                   in_a_is_box,
  input  logic [COORD_WIDTH-1:0] in_a_x,
  input  logic [COORD_WIDTH-1:0] in_a_y,
  input  logic [COORD_WIDTH-2:0] in_a_size_x,
  input  logic [COORD_WIDTH-2:0] in_a_size_y,
  input  logic                   in_b_is_box,
  input  logic [COORD_WIDTH-1:0] in_b_x,
  input  logic [COORD_WIDTH-1:0] in_b_y,
  input  logic [COORD_WIDTH-2:0] in_b_size_x,
  input  logic [COORD_WIDTH-2:0] in_b_size_y,
  output logic                   out_valid,
  output logic                   out_hit
);
  import cbot_pkg::*;

  localparam int unsigned W = COORD_WIDTH;

  cbot_ctl_t    ctl_in, ctl_d;
  cbot_tst_t    tst_d;
  logic [W-1:0] dx_d, dy_d;
  logic [W-2:0] asx_d, asy_d, bsx_d, bsy_d;
  logic [W-1:0] gx_d, gy_d, rad_d;

  // the pipeline never stalls
  assign busy = 1'b0;

  // item entry
  always_comb begin
    ctl_in.valid = start && !busy;
    ctl_in.point = in_kind;
    ctl_in.a_box = in_a_is_box;
    ctl_in.b_box = in_b_is_box;
  end

  cbot_dist #(.COORD_WIDTH(W)) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_in   (ctl_in),
    .a_x      (in_a_x),
    .a_y      (in_a_y),
    .a_size_x (in_a_size_x),
    .a_size_y (in_a_size_y),
    .b_x      (in_b_x),
    .b_y      (in_b_y),
    .b_size_x (in_b_size_x),
    .b_size_y (in_b_size_y),
    .ctl_r    (ctl_d),
    .dx_r     (dx_d),
    .dy_r     (dy_d),
    .asx_r    (asx_d),
    .asy_r    (asy_d),
    .bsx_r    (bsx_d),
    .bsy_r    (bsy_d)
  );

  cbot_reduce #(.COORD_WIDTH(W)) u_reduce (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl_d),
    .dx    (dx_d),
    .dy    (dy_d),
    .asx   (asx_d),
    .asy   (asy_d),
    .bsx   (bsx_d),
    .bsy   (bsy_d),
    .tst_r (tst_d),
    .gx_r  (gx_d),
    .gy_r  (gy_d),
    .rad_r (rad_d)
  );

  cbot_radius #(.COORD_WIDTH(W)) u_radius (
    .clk     (clk),
    .rst_n   (rst_n),
    .tst     (tst_d),
    .gx      (gx_d),
    .gy      (gy_d),
    .rad     (rad_d),
    .valid_r (out_valid),
    .hit_r   (out_hit)
  );

endmodule

// ===== hw/rtl/cbot_checker.sv =====
module cbot_checker #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   start,
  input logic                   busy,
  input logic [COORD_WIDTH-1:0] in_a_x,
  input logic [COORD_WIDTH-1:0] in_a_y,
  input logic [COORD_WIDTH-1:0] in_b_x,
  input logic [COORD_WIDTH-1:0] in_b_y,
  input logic                   out_valid,
  input logic                   out_hit
);
  import cbot_pkg::*;

  // the unit always takes items
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // every item gives a verdict
  a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_valid)
    else $error("item lost");

  // no verdict without an item
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 4))
    else $error("verdict without item");

  // shapes or a point sharing a centre always overlap
  a_same_centre: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_a_x == in_b_x && in_a_y == in_b_y) |-> ##4 out_hit)
    else $error("shared centre missed");

endmodule

bind circle_box_overlap_test_unit cbot_checker #(.COORD_WIDTH(COORD_WIDTH)) u_cbot_checker (.*);
